@@ design/sme_pkg.sv @@
// ----------------------------------------------------------------------------
// sme_pkg: shared types and constants of the stack machine execute block
// opcodes, status codes, payload structs and the front-to-back queue entry
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int StackDepth = 16;
    localparam int PcWidth = 16;
    localparam int NumRegisters = 8;
    localparam int MaxResults = 16;
    localparam int CntW = $clog2(StackDepth + 1);
    localparam int SpW = $clog2(StackDepth);
    localparam int RegW = $clog2(NumRegisters);

    typedef enum logic [4:0] {
        OP_PUSH = 5'd0, OP_POP = 5'd1, OP_DUP = 5'd2, OP_SWAP = 5'd3,
        OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MULT = 5'd6, OP_DIV = 5'd7,
        OP_GOTO = 5'd8, OP_JMPEQ = 5'd9, OP_JMPGT = 5'd10, OP_JMPGE = 5'd11,
        OP_JMPLT = 5'd12, OP_JMPLE = 5'd13, OP_SKIP = 5'd14, OP_STORE = 5'd15,
        OP_LOAD = 5'd16, OP_PRINT = 5'd17
    } opcode_t;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER = 3'd2;
    localparam logic [2:0] ST_BADREG = 3'd3;
    localparam logic [2:0] ST_DIVZERO = 3'd4;
    localparam logic [2:0] ST_BADOP = 3'd5;

    typedef struct packed {
        logic [4:0] command;
        logic signed [31:0] argument;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [15:0] next_pc;
        logic print_valid;
        logic signed [31:0] print_value;
        logic last;
    } out_item_t;

    // decoded instruction as handed from front to back
    typedef struct packed {
        logic [4:0] command;
        logic [31:0] argument;
        logic bad_op;
        logic reg_ok;
        logic [RegW-1:0] reg_idx;
    } dec_item_t;

endpackage

@@ design/sme_front.sv @@
// ----------------------------------------------------------------------------
// sme_front: instruction intake
// accepts instructions, classifies opcode and register index, fills a queue
// ----------------------------------------------------------------------------
module sme_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sme_pkg::in_item_t    in_data,
    output logic                 q_valid,
    input  logic                 q_ready,
    output sme_pkg::dec_item_t   q_data
);

    logic [1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    sme_pkg::dec_item_t mem [4];
    sme_pkg::dec_item_t dec;
    logic push, pop;

    // classify the incoming instruction
    always_comb
    begin
        dec.command = in_data.command;
        dec.argument = in_data.argument;
        dec.bad_op = (in_data.command > 5'(sme_pkg::OP_PRINT));
        dec.reg_ok = (in_data.argument[31:sme_pkg::RegW] == '0);
        dec.reg_idx = in_data.argument[sme_pkg::RegW-1:0];
    end

    assign in_ready = (cnt_reg != 3'd4);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 3'd0);
    assign pop = q_valid && q_ready;
    assign q_data = mem[rp_reg];
    assign wp_next = push ? wp_reg + 2'd1 : wp_reg;
    assign rp_next = pop ? rp_reg + 2'd1 : rp_reg;
    assign cnt_next = cnt_reg + {2'b0, push} - {2'b0, pop};

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= dec;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("queue count out of range");
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 3'd4 |-> !in_ready)
        else $error("full queue accepts");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 3'd0 |-> wp_reg == rp_reg)
        else $error("empty queue pointers differ");

endmodule

@@ design/sme_divider.sv @@
// ----------------------------------------------------------------------------
// sme_divider: signed division unit
// restoring radix-2 divider, one quotient bit a cycle, truncates toward zero
// ----------------------------------------------------------------------------
module sme_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg, rem_next, q_reg, q_next, d_reg, d_next;
    logic [5:0] cnt_reg, cnt_next;
    logic neg_reg, neg_next, busy_reg, busy_next, done_reg, done_next;
    logic [32:0] trial;

    assign trial = {rem_reg, q_reg[31]} - {1'b0, d_reg};
    assign done = done_reg;
    assign quotient = neg_reg ? 32'd0 - q_reg : q_reg;

    // iteration control
    always_comb
    begin
        rem_next = rem_reg;
        q_next = q_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            q_next = dividend[31] ? 32'd0 - dividend : dividend;
            d_next = divisor[31] ? 32'd0 - divisor : divisor;
            neg_next = dividend[31] ^ divisor[31];
            cnt_next = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg <= q_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

@@ design/sme_back.sv @@
// ----------------------------------------------------------------------------
// sme_back: instruction execution
// holds stack, registers and pc; executes one instruction and emits results
// ----------------------------------------------------------------------------
module sme_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  sme_pkg::dec_item_t   q_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sme_pkg::out_item_t   out_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_MUL, S_DIV, S_PRINT, S_OUT
    } state_t;

    localparam int Sp = sme_pkg::SpW;
    localparam int Cw = sme_pkg::CntW;
    localparam int Pw = sme_pkg::PcWidth;

    state_t state_reg;
    sme_pkg::dec_item_t ins_reg;
    logic [Cw-1:0] n_reg;
    logic [Pw-1:0] pc_reg;
    logic [31:0] stk [sme_pkg::StackDepth];
    logic [31:0] regs_reg [sme_pkg::NumRegisters];
    logic [31:0] top_reg, nxt_reg, prod_reg;
    logic [Cw-1:0] pidx_reg;
    logic [Cw-1:0] pleft_reg;
    logic out_valid_reg;
    sme_pkg::out_item_t out_reg;

    logic div_start, div_done;
    logic [31:0] div_q;
    logic [Pw-1:0] pc_inc, pc_arg;
    logic full, has1, has2;
    logic ob_free;

    // branch condition of the compare-jumps, a is next and b is top
    function automatic logic take_jump(input logic [4:0] cmd, input logic [31:0] a,
                                       input logic [31:0] b);
        logic lt, gt;
        lt = $signed(a) < $signed(b);
        gt = $signed(a) > $signed(b);
        unique case (cmd)
            5'(sme_pkg::OP_JMPEQ): take_jump = (a == b);
            5'(sme_pkg::OP_JMPGT): take_jump = gt;
            5'(sme_pkg::OP_JMPGE): take_jump = !lt;
            5'(sme_pkg::OP_JMPLT): take_jump = lt;
            default:               take_jump = !gt;
        endcase
    endfunction

    sme_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(nxt_reg), .divisor(top_reg),
        .done(div_done), .quotient(div_q)
    );

    assign pc_inc = pc_reg + 1'b1;
    assign pc_arg = ins_reg.argument[Pw-1:0];
    assign full = (n_reg == Cw'(sme_pkg::StackDepth));
    assign has1 = (n_reg != '0);
    assign has2 = (n_reg > Cw'(1));
    assign ob_free = !out_valid_reg || out_ready;
    assign q_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign div_start = (state_reg == S_EXEC) && ob_free && has2
                       && ins_reg.command == 5'(sme_pkg::OP_DIV) && !ins_reg.bad_op
                       && top_reg != '0;

    // sequencer, machine state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg <= '0;
            pc_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < sme_pkg::NumRegisters; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (ob_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.status <= sme_pkg::ST_OK;
                        out_reg.next_pc <= 16'(pc_inc);
                        out_reg.print_valid <= 1'b0;
                        out_reg.print_value <= '0;
                        out_reg.last <= 1'b1;
                        state_reg <= S_IDLE;
                        if (ins_reg.bad_op)
                        begin
                            out_reg.status <= sme_pkg::ST_BADOP;
                            out_reg.next_pc <= 16'(pc_reg);
                        end
                        else
                        begin
                            unique case (sme_pkg::opcode_t'(ins_reg.command))
                                sme_pkg::OP_PUSH, sme_pkg::OP_DUP, sme_pkg::OP_LOAD:
                                begin
                                    if (ins_reg.command == 5'(sme_pkg::OP_DUP) && !has1)
                                    begin
                                        out_reg.status <= sme_pkg::ST_UNDER;
                                        out_reg.next_pc <= 16'(pc_reg);
                                    end
                                    else if (ins_reg.command == 5'(sme_pkg::OP_LOAD)
                                             && !ins_reg.reg_ok)
                                    begin
                                        out_reg.status <= sme_pkg::ST_BADREG;
                                        out_reg.next_pc <= 16'(pc_reg);
                                    end
                                    else if (full)
                                    begin
                                        out_reg.status <= sme_pkg::ST_OVER;
                                        out_reg.next_pc <= 16'(pc_reg);
                                    end
                                    else
                                    begin
                                        n_reg <= n_reg + 1'b1;
                                        pc_reg <= pc_inc;
                                    end
                                end
                                sme_pkg::OP_POP:
                                begin
                                    if (!has1)
                                    begin
                                        out_reg.status <= sme_pkg::ST_UNDER;
                                        out_reg.next_pc <= 16'(pc_reg);
                                    end
                                    else
                                    begin
                                        n_reg <= n_reg - 1'b1;
                                        pc_reg <= pc_inc;
                                    end
                                end
                                sme_pkg::OP_STORE:
                                begin
                                    if (!has1)
                                    begin
                                        out_reg.status <= sme_pkg::ST_UNDER;
                                        out_reg.next_pc <= 16'(pc_reg);
                                    end
                                    else if (!ins_reg.reg_ok)
                                    begin
                                        out_reg.status <= sme_pkg::ST_BADREG;
                                        out_reg.next_pc <= 16'(pc_reg);
                                    end
                                    else
                                    begin
                                        regs_reg[ins_reg.reg_idx] <= top_reg;
                                        n_reg <= n_reg - 1'b1;
                                        pc_reg <= pc_inc;
                                    end
                                end
                                sme_pkg::OP_SWAP, sme_pkg::OP_ADD, sme_pkg::OP_SUB:
                                begin
                                    if (!has2)
                                    begin
                                        out_reg.status <= sme_pkg::ST_UNDER;
                                        out_reg.next_pc <= 16'(pc_reg);
                                    end
                                    else
                                    begin
                                        if (ins_reg.command != 5'(sme_pkg::OP_SWAP))
                                        begin
                                            n_reg <= n_reg - 1'b1;
                                        end
                                        pc_reg <= pc_inc;
                                    end
                                end
                                sme_pkg::OP_MULT, sme_pkg::OP_DIV:
                                begin
                                    if (!has2)
                                    begin
                                        out_reg.status <= sme_pkg::ST_UNDER;
                                        out_reg.next_pc <= 16'(pc_reg);
                                    end
                                    else if (ins_reg.command == 5'(sme_pkg::OP_DIV)
                                             && top_reg == '0)
                                    begin
                                        out_reg.status <= sme_pkg::ST_DIVZERO;
                                        out_reg.next_pc <= 16'(pc_reg);
                                    end
                                    else
                                    begin
                                        // result comes from a multi-cycle unit
                                        out_valid_reg <= 1'b0;
                                        state_reg <= (ins_reg.command ==
                                            5'(sme_pkg::OP_MULT)) ? S_MUL : S_DIV;
                                    end
                                end
                                sme_pkg::OP_GOTO:
                                begin
                                    pc_reg <= pc_arg;
                                    out_reg.next_pc <= 16'(pc_arg);
                                end
                                sme_pkg::OP_JMPEQ, sme_pkg::OP_JMPGT, sme_pkg::OP_JMPGE,
                                sme_pkg::OP_JMPLT, sme_pkg::OP_JMPLE:
                                begin
                                    if (!has2)
                                    begin
                                        out_reg.status <= sme_pkg::ST_UNDER;
                                        out_reg.next_pc <= 16'(pc_reg);
                                    end
                                    else
                                    begin
                                        n_reg <= n_reg - Cw'(2);
                                        if (take_jump(ins_reg.command, nxt_reg, top_reg))
                                        begin
                                            pc_reg <= pc_arg;
                                            out_reg.next_pc <= 16'(pc_arg);
                                        end
                                        else
                                        begin
                                            pc_reg <= pc_inc;
                                        end
                                    end
                                end
                                sme_pkg::OP_SKIP:
                                begin
                                    pc_reg <= pc_inc;
                                end
                                sme_pkg::OP_PRINT:
                                begin
                                    pc_reg <= pc_inc;
                                    if (has1)
                                    begin
                                        out_valid_reg <= 1'b0;
                                        state_reg <= S_PRINT;
                                    end
                                end
                                default:
                                begin
                                    out_reg.status <= sme_pkg::ST_BADOP;
                                end
                            endcase
                        end
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_OUT;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (ob_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.status <= sme_pkg::ST_OK;
                        out_reg.next_pc <= 16'(pc_inc);
                        out_reg.print_valid <= 1'b0;
                        out_reg.print_value <= '0;
                        out_reg.last <= 1'b1;
                        n_reg <= n_reg - 1'b1;
                        pc_reg <= pc_inc;
                        state_reg <= S_IDLE;
                    end
                end
                S_PRINT:
                begin
                    if (ob_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.status <= sme_pkg::ST_OK;
                        out_reg.next_pc <= 16'(pc_reg);
                        out_reg.print_valid <= 1'b1;
                        out_reg.print_value <= stk[pidx_reg[Sp-1:0]];
                        out_reg.last <= (pleft_reg == Cw'(1));
                        if (pleft_reg == Cw'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // operand fetch, stack writes, product and print walk
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid)
        begin
            ins_reg <= q_data;
            top_reg <= has1 ? stk[Sp'(n_reg - 1'b1)] : '0;
            nxt_reg <= has2 ? stk[Sp'(n_reg - Cw'(2))] : '0;
        end
        if (state_reg == S_EXEC && ob_free && !ins_reg.bad_op)
        begin
            pidx_reg <= n_reg - 1'b1;
            pleft_reg <= (n_reg > Cw'(sme_pkg::MaxResults)) ?
                         Cw'(sme_pkg::MaxResults) : n_reg;
            unique case (sme_pkg::opcode_t'(ins_reg.command))
                sme_pkg::OP_PUSH:
                    if (!full) stk[Sp'(n_reg)] <= ins_reg.argument;
                sme_pkg::OP_DUP:
                    if (!full && has1) stk[Sp'(n_reg)] <= top_reg;
                sme_pkg::OP_LOAD:
                    if (!full && ins_reg.reg_ok) stk[Sp'(n_reg)] <= regs_reg[ins_reg.reg_idx];
                sme_pkg::OP_SWAP:
                    if (has2)
                    begin
                        stk[Sp'(n_reg - Cw'(2))] <= top_reg;
                        stk[Sp'(n_reg - 1'b1)] <= nxt_reg;
                    end
                sme_pkg::OP_ADD:
                    if (has2) stk[Sp'(n_reg - Cw'(2))] <= nxt_reg + top_reg;
                sme_pkg::OP_SUB:
                    if (has2) stk[Sp'(n_reg - Cw'(2))] <= nxt_reg - top_reg;
                default:
                begin
                end
            endcase
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= 32'(nxt_reg * top_reg);
        end
        if (state_reg == S_DIV && div_done)
        begin
            prod_reg <= div_q;
        end
        if (state_reg == S_OUT && ob_free)
        begin
            stk[Sp'(n_reg - Cw'(2))] <= prod_reg;
        end
        if (state_reg == S_PRINT && ob_free)
        begin
            pidx_reg <= pidx_reg - 1'b1;
            pleft_reg <= pleft_reg - 1'b1;
        end
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= Cw'(sme_pkg::StackDepth))
        else $error("stack count beyond depth");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PRINT && ob_free && pleft_reg == Cw'(1) |=> state_reg == S_IDLE)
        else $error("print did not end");
    a_err_pc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && out_reg.status != sme_pkg::ST_OK
        |-> out_reg.next_pc == 16'(pc_reg))
        else $error("error changed pc");
    a_pleft: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PRINT |-> pleft_reg != '0)
        else $error("print count empty");

endmodule

@@ design/stack_machine_execute.sv @@
// ----------------------------------------------------------------------------
// stack_machine_execute: stack machine execution unit
// executes instructions over an operand stack, registers and pc
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready, in_data) transfers one instruction:
//   command and signed argument. out channel (out_valid/out_ready, out_data)
//   transfers result items: status, next_pc, print_valid, print_value, last.
//   Every instruction gives one result with last set, except print on a
//   non-empty stack, which gives one result per entry (top first, up to 16).
//   A four-entry queue decouples intake from execution, so instructions are
//   taken while the execution side works or waits on the receiver.
//   Each instruction passes from the queue head through the operand fetch
//   and the execute step that loads the output register; the execution side
//   takes a new instruction only when the previous one has given its result;
//   mult adds the registered multiplier step, div waits on the radix-2
//   divider, and print emits its entries one after another.
//   Reset clears the stack count, registers, pc and queue; no clearing pass.
//   When the receiver stalls, the result holds in the output register and the
//   execution side waits; intake goes on until the queue fills.
// ----------------------------------------------------------------------------
module stack_machine_execute (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sme_pkg::in_item_t     in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sme_pkg::out_item_t    out_data
);

    logic q_valid, q_ready;
    sme_pkg::dec_item_t q_data;

    sme_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    sme_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule

@@ dv/tb_stack_machine_execute.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stack_machine_execute: self-checking bench of the stack machine unit
// drives instructions, predicts every result item from an internal
// model of stack, registers and pc, and compares transfers in order
// ----------------------------------------------------------------------------
module tb_stack_machine_execute;

    localparam int WatchLimit = 20000;
    localparam int DrainCycles = 60;
    localparam logic [4:0] BadOpLow = 5'd18;
    localparam logic [4:0] BadOpHigh = 5'd31;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    sme_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    sme_pkg::out_item_t out_data;

    // machine state as predicted
    logic [31:0] model_stack [sme_pkg::StackDepth];
    int model_count;
    logic [31:0] model_regs [sme_pkg::NumRegisters];
    logic [15:0] model_pc;

    sme_pkg::in_item_t pending_instrs [$];
    sme_pkg::out_item_t expected_results [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_receiver = 1'b0;
    int hold_cycles = 0;
    bit stim_done = 1'b0;
    int mismatches = 0;
    int results_seen = 0;
    int instrs_sent = 0;
    int prints_seen = 0;
    int errors_seen = 0;
    int quiet_cycles = 0;

    stack_machine_execute dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #6 clk = ~clk;

    function automatic sme_pkg::out_item_t make_result(logic [2:0] st, logic pv,
                                                       logic [31:0] val, logic lst);
        sme_pkg::out_item_t r;
        r.status = st;
        r.next_pc = model_pc;
        r.print_valid = pv;
        r.print_value = val;
        r.last = lst;
        return r;
    endfunction

    function automatic bit signed_less(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // work out results of one instruction and advance the predicted state
    task automatic execute_instr(sme_pkg::in_item_t it);
        logic [4:0] cmd;
        logic [31:0] arg;
        logic [31:0] top;
        logic [31:0] nxt;
        logic [31:0] res;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [2:0] st;
        logic [15:0] new_pc;
        int n;
        int cnt;
        bit jump;
        cmd = it.command;
        arg = it.argument;
        n = model_count;
        top = (n >= 1) ? model_stack[n-1] : '0;
        nxt = (n >= 2) ? model_stack[n-2] : '0;
        st = sme_pkg::ST_OK;
        new_pc = model_pc + 16'd1;
        jump = 1'b0;
        case (cmd)
            sme_pkg::OP_PUSH:
                if (n >= sme_pkg::StackDepth) st = sme_pkg::ST_OVER;
                else begin model_stack[n] = arg; n++; end
            sme_pkg::OP_POP:
                if (n < 1) st = sme_pkg::ST_UNDER;
                else n--;
            sme_pkg::OP_DUP:
                if (n < 1) st = sme_pkg::ST_UNDER;
                else if (n >= sme_pkg::StackDepth) st = sme_pkg::ST_OVER;
                else begin model_stack[n] = top; n++; end
            sme_pkg::OP_SWAP, sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MULT,
            sme_pkg::OP_DIV:
                if (n < 2) st = sme_pkg::ST_UNDER;
                else if (cmd == sme_pkg::OP_SWAP)
                begin
                    model_stack[n-2] = top;
                    model_stack[n-1] = nxt;
                end
                else if (cmd == sme_pkg::OP_DIV && top == 0) st = sme_pkg::ST_DIVZERO;
                else
                begin
                    if (cmd == sme_pkg::OP_ADD) res = nxt + top;
                    else if (cmd == sme_pkg::OP_SUB) res = nxt - top;
                    else if (cmd == sme_pkg::OP_MULT) res = nxt * top;
                    else
                    begin
                        ma = nxt[31] ? -nxt : nxt;
                        mb = top[31] ? -top : top;
                        res = ma / mb;
                        if (nxt[31] != top[31]) res = -res;
                    end
                    model_stack[n-2] = res;
                    n--;
                end
            sme_pkg::OP_GOTO:
                new_pc = arg[15:0];
            sme_pkg::OP_JMPEQ, sme_pkg::OP_JMPGT, sme_pkg::OP_JMPGE, sme_pkg::OP_JMPLT,
            sme_pkg::OP_JMPLE:
                if (n < 2) st = sme_pkg::ST_UNDER;
                else
                begin
                    case (cmd)
                        sme_pkg::OP_JMPEQ: jump = (nxt == top);
                        sme_pkg::OP_JMPGT: jump = signed_less(top, nxt);
                        sme_pkg::OP_JMPGE: jump = !signed_less(nxt, top);
                        sme_pkg::OP_JMPLT: jump = signed_less(nxt, top);
                        default:           jump = !signed_less(top, nxt);
                    endcase
                    n -= 2;
                    if (jump) new_pc = arg[15:0];
                end
            sme_pkg::OP_SKIP, sme_pkg::OP_PRINT: ;
            sme_pkg::OP_STORE:
                if (n < 1) st = sme_pkg::ST_UNDER;
                else if (arg >= sme_pkg::NumRegisters) st = sme_pkg::ST_BADREG;
                else begin model_regs[arg[2:0]] = top; n--; end
            sme_pkg::OP_LOAD:
                if (arg >= sme_pkg::NumRegisters) st = sme_pkg::ST_BADREG;
                else if (n >= sme_pkg::StackDepth) st = sme_pkg::ST_OVER;
                else begin model_stack[n] = model_regs[arg[2:0]]; n++; end
            default:
                st = sme_pkg::ST_BADOP;
        endcase
        if (st != sme_pkg::ST_OK)
        begin
            errors_seen++;
            expected_results.push_back(make_result(st, 1'b0, '0, 1'b1));
        end
        else
        begin
            model_count = n;
            model_pc = new_pc;
            if (cmd == sme_pkg::OP_PRINT && n > 0)
            begin
                cnt = (n > sme_pkg::MaxResults) ? sme_pkg::MaxResults : n;
                for (int k = 0; k < cnt; k++)
                    expected_results.push_back(make_result(sme_pkg::ST_OK, 1'b1,
                        model_stack[n-1-k], k + 1 == cnt));
            end
            else
                expected_results.push_back(make_result(sme_pkg::ST_OK, 1'b0, '0, 1'b1));
        end
    endtask

    function automatic sme_pkg::in_item_t instr(logic [4:0] cmd, logic [31:0] arg);
        sme_pkg::in_item_t it;
        it.command = cmd;
        it.argument = arg;
        return it;
    endfunction

    // random value favoring corner values
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // random instruction, mostly legal and well-formed
    function automatic sme_pkg::in_item_t rand_instr();
        int pick;
        logic [31:0] arg;
        pick = $urandom_range(0, 99);
        arg = rand_value();
        if (pick < 22) return instr(sme_pkg::OP_PUSH, arg);
        if (pick < 25) return instr(5'($urandom_range(BadOpLow, BadOpHigh)), $urandom);
        if (pick < 32) return instr(sme_pkg::OP_STORE, ($urandom_range(0, 9) == 0) ? arg
                                    : $urandom_range(0, 7));
        if (pick < 40) return instr(sme_pkg::OP_LOAD, ($urandom_range(0, 9) == 0) ? arg
                                    : $urandom_range(0, 7));
        if (pick < 44) return instr(sme_pkg::OP_PRINT, $urandom);
        return instr(5'($urandom_range(sme_pkg::OP_POP, sme_pkg::OP_SKIP)), arg);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            instrs_sent <= instrs_sent + 1;
        if (!in_valid || in_ready)
        begin
            if (pending_instrs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_data <= pending_instrs.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall and long hold-off
    always @(posedge clk)
    begin
        if (hold_receiver && hold_cycles < 300)
        begin
            hold_cycles <= hold_cycles + 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor and checker
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (out_data.print_valid) prints_seen <= prints_seen + 1;
            if (expected_results.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("ERROR: unexpected result transfer %p", out_data);
            end
            else
            begin
                sme_pkg::out_item_t exp_r;
                exp_r = expected_results.pop_front();
                if (out_data !== exp_r)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("ERROR: result %0d expected %p got %p",
                                 results_seen, exp_r, out_data);
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (!hold_receiver || hold_cycles >= 300)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WatchLimit)
        begin
            $display("ERROR: watchdog timeout");
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_instr(sme_pkg::in_item_t it);
        execute_instr(it);
        pending_instrs.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_instrs.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int items, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < items; i++)
            queue_instr(rand_instr());
        wait_drained();
    endtask

    initial
    begin
        model_count = 0;
        model_pc = '0;
        foreach (model_regs[i]) model_regs[i] = '0;
        foreach (model_stack[i]) model_stack[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: errors on empty machine, extremes, every opcode but the ordered compare-jumps
        queue_instr(instr(sme_pkg::OP_POP, 0));
        queue_instr(instr(sme_pkg::OP_PRINT, 0));
        queue_instr(instr(sme_pkg::OP_STORE, 3));
        queue_instr(instr(sme_pkg::OP_LOAD, 32'hffff_ffff));
        queue_instr(instr(sme_pkg::OP_LOAD, 8));
        queue_instr(instr(BadOpHigh, 32'hffff_ffff));
        queue_instr(instr(BadOpLow, 0));
        queue_instr(instr(sme_pkg::OP_PUSH, 32'h8000_0000));
        queue_instr(instr(sme_pkg::OP_PUSH, 32'hffff_ffff));
        queue_instr(instr(sme_pkg::OP_DUP, 0));
        queue_instr(instr(sme_pkg::OP_SWAP, 0));
        queue_instr(instr(sme_pkg::OP_DIV, 0));
        queue_instr(instr(sme_pkg::OP_PUSH, 0));
        queue_instr(instr(sme_pkg::OP_DIV, 0));
        queue_instr(instr(sme_pkg::OP_ADD, 0));
        queue_instr(instr(sme_pkg::OP_PUSH, 32'h7fff_ffff));
        queue_instr(instr(sme_pkg::OP_MULT, 0));
        queue_instr(instr(sme_pkg::OP_SUB, 0));
        queue_instr(instr(sme_pkg::OP_PUSH, 32'hffff_fff9));
        queue_instr(instr(sme_pkg::OP_JMPEQ, 32'h0001_ffff));
        queue_instr(instr(sme_pkg::OP_GOTO, 32'hffff_ffff));
        queue_instr(instr(sme_pkg::OP_SKIP, 0));
        queue_instr(instr(sme_pkg::OP_STORE, 7));
        queue_instr(instr(sme_pkg::OP_LOAD, 7));
        wait_drained();

        // full stack: overflow, deepest print, then compare-jumps
        for (int i = 0; i < 17; i++)
            queue_instr(instr(sme_pkg::OP_PUSH, rand_value()));
        queue_instr(instr(sme_pkg::OP_DUP, 0));
        queue_instr(instr(sme_pkg::OP_LOAD, 0));
        queue_instr(instr(sme_pkg::OP_PRINT, 0));
        for (int op = sme_pkg::OP_JMPEQ; op <= sme_pkg::OP_JMPLE; op++)
            queue_instr(instr(5'(op), $urandom));
        queue_instr(instr(sme_pkg::OP_PUSH, 32'h7fff_ffff));
        queue_instr(instr(sme_pkg::OP_DUP, 0));
        queue_instr(instr(sme_pkg::OP_JMPGE, 5));
        wait_drained();

        run_phase(60, 0, 0);
        run_phase(90, 57, 0);
        run_phase(90, 0, 57);
        run_phase(90, 31, 31);

        // long receiver hold-off while instructions keep coming
        hold_receiver = 1'b1;
        run_phase(60, 0, 0);
        hold_receiver = 1'b0;
        run_phase(40, 10, 10);

        stim_done = 1'b1;
        repeat (DrainCycles) @(posedge clk);
        $display("Ran %0d instructions, checked %0d results (%0d printed entries, %0d errors)",
                 instrs_sent, results_seen, prints_seen, errors_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
